/* rtl/core/pali_pkg.sv */
package pali_pkg;

    localparam int VERTICES_DEF      = 16;
    localparam int EDGE_CAPACITY_DEF = 1024;

    localparam int ID_W  = 4;
    localparam int LEN_W = 11;
    localparam int REQ_W = 3;
    localparam int POS_W = 10;
    localparam int STS_W = 2;

    localparam logic [REQ_W-1:0] REQ_ADD_PARENT   = 3'd0;
    localparam logic [REQ_W-1:0] REQ_ADD_CHILD    = 3'd1;
    localparam logic [REQ_W-1:0] REQ_ADD_NEIGHBOR = 3'd2;
    localparam logic [REQ_W-1:0] REQ_ADD_SIBLING  = 3'd3;
    localparam logic [REQ_W-1:0] REQ_READ         = 3'd4;

    localparam logic [STS_W-1:0] STS_OK    = 2'd0;
    localparam logic [STS_W-1:0] STS_FULL  = 2'd1;
    localparam logic [STS_W-1:0] STS_RANGE = 2'd2;

    typedef struct packed {
        logic shift;
        logic bump_start;
        logic bump_count;
    } ring_ctl_t;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_SCAN = 5'b00010,
        S_MOVE = 5'b00100,
        S_RD   = 5'b01000,
        S_FIN  = 5'b10000
    } state_t;

endpackage

/* rtl/core/pali_cell.sv */
// One list descriptor: start offset and length. Take the neighbor's entry on shift,
// bumping either field as requested.
module pali_cell #(
    parameter int CNT_W = 11
) (
    input  logic                clk,
    input  logic                rst_n,
    input  pali_pkg::ring_ctl_t ctl,
    input  logic [CNT_W-1:0]    start_in,
    input  logic [CNT_W-1:0]    count_in,
    output logic [CNT_W-1:0]    start_out,
    output logic [CNT_W-1:0]    count_out
);

    logic [CNT_W-1:0] start_reg, start_next;
    logic [CNT_W-1:0] count_reg, count_next;

    always_comb
    begin
        start_next = start_reg;
        count_next = count_reg;
        if (ctl.shift)
        begin
            start_next = start_in + CNT_W'(ctl.bump_start);
            count_next = count_in + CNT_W'(ctl.bump_count);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            start_reg <= start_next;
            count_reg <= count_next;
        end
    end

    assign start_out = start_reg;
    assign count_out = count_reg;

endmodule

/* rtl/core/pali_ring.sv */
// Circular chain of list descriptors. Cell 0 is the head; on each shift every
// cell takes its upper neighbor, and the last cell takes the head with updates applied.
module pali_ring #(
    parameter int LISTS = 64,
    parameter int CNT_W = 11
) (
    input  logic                clk,
    input  logic                rst_n,
    input  pali_pkg::ring_ctl_t ctl,
    output logic [CNT_W-1:0]    head_start,
    output logic [CNT_W-1:0]    head_count
);

    logic [CNT_W-1:0] start_q [LISTS];
    logic [CNT_W-1:0] count_q [LISTS];

    for (genvar i = 0; i < LISTS; i++)
    begin : g_cell
        pali_pkg::ring_ctl_t cell_ctl;
        logic [CNT_W-1:0]    start_in;
        logic [CNT_W-1:0]    count_in;

        if (i == LISTS - 1)
        begin : g_tail
            assign cell_ctl = ctl;
            assign start_in = start_q[0];
            assign count_in = count_q[0];
        end
        else
        begin : g_body
            assign cell_ctl = '{shift: ctl.shift, bump_start: 1'b0, bump_count: 1'b0};
            assign start_in = start_q[i+1];
            assign count_in = count_q[i+1];
        end

        pali_cell #(
            .CNT_W(CNT_W)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctl      (cell_ctl),
            .start_in (start_in),
            .count_in (count_in),
            .start_out(start_q[i]),
            .count_out(count_q[i])
        );
    end

    assign head_start = start_q[0];
    assign head_count = count_q[0];

endmodule

/* rtl/core/packed_adjacency_list_insert_core.sv */
// Packed adjacency store with ordered insert. Every vertex owns four lists
// (parents, children, neighbors, siblings) packed back to back in one edge memory,
// vertex 0 first. Issue a transaction by raising start while busy is low; the
// request fields are sampled on that edge. Each transaction returns exactly one
// result on status/read_value/list_length/total_edges, valid for the single cycle
// in which done is high; the receiver cannot stall it, so capture it then.
// Every transaction first walks the ring of list descriptors once to find its
// list and, on an insert, to advance every later list start. An insert then
// moves each later edge up one place through the single-port-write edge
// memory, one entry per cycle, then retires the last fetched entry and writes
// the new id; when nothing moves it only writes the new id. Any other
// transaction does a registered memory read instead. The result state then
// forms the result and registers it together with done. busy drops in the done
// cycle, so the next transaction can be taken on the edge that ends it.
// An insert for a valid vertex into a full store is dropped with status 1; a vertex beyond VERTICES
// gives list_length 0. The edge memory needs no clearing after reset.
module packed_adjacency_list_insert_core #(
    parameter int VERTICES      = pali_pkg::VERTICES_DEF,
    parameter int EDGE_CAPACITY = pali_pkg::EDGE_CAPACITY_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [pali_pkg::REQ_W-1:0] req_type,
    input  logic [3:0]                 vertex,
    input  logic [pali_pkg::ID_W-1:0]  other_vertex,
    input  logic [1:0]                 list_kind,
    input  logic [pali_pkg::POS_W-1:0] position,
    output logic                       done,
    output logic [pali_pkg::STS_W-1:0] status,
    output logic [pali_pkg::ID_W-1:0]  read_value,
    output logic [pali_pkg::LEN_W-1:0] list_length,
    output logic [pali_pkg::LEN_W-1:0] total_edges
);

    localparam int LISTS  = 4 * VERTICES;
    localparam int SLOT_W = $clog2(LISTS);
    localparam int ADDR_W = $clog2(EDGE_CAPACITY);
    localparam int CNT_W  = $clog2(EDGE_CAPACITY + 1);
    localparam int ID_W   = pali_pkg::ID_W;
    localparam int LEN_W  = pali_pkg::LEN_W;

    // Control state
    pali_pkg::state_t state_reg, state_next;
    logic [SLOT_W-1:0] rot_reg, rot_next;
    logic [CNT_W-1:0]  total_reg, total_next;
    logic              wr_pend_reg, wr_pend_next;
    logic              done_reg, done_next;

    // Transaction context
    logic [SLOT_W-1:0]                slot_reg, slot_next;
    logic [ID_W-1:0]                  id_reg, id_next;
    logic [pali_pkg::POS_W-1:0]       pos_in_reg, pos_in_next;
    logic                             vld_reg, vld_next;
    logic                             rdreq_reg, rdreq_next;
    logic                             do_ins_reg, do_ins_next;
    logic                             full_reg, full_next;
    logic                             rd_ok_reg, rd_ok_next;
    logic [CNT_W-1:0]                 st_reg, st_next;
    logic [CNT_W-1:0]                 cnt_reg, cnt_next;
    logic [CNT_W-1:0]                 mv_dst_reg, mv_dst_next;
    logic [ADDR_W-1:0]                wr_addr_reg, wr_addr_next;

    // Result
    logic [pali_pkg::STS_W-1:0] status_reg, status_next;
    logic [ID_W-1:0]            value_reg, value_next;
    logic [LEN_W-1:0]           length_reg, length_next;

    // Ring and memory
    pali_pkg::ring_ctl_t ring_ctl;
    logic [CNT_W-1:0]    head_start, head_count;
    logic [ID_W-1:0]     edge_mem [EDGE_CAPACITY];
    logic [ID_W-1:0]     rd_data_reg;
    logic                mem_we, mem_re;
    logic [ADDR_W-1:0]   mem_waddr, mem_raddr;
    logic [ID_W-1:0]     mem_wdata;

    logic        accept;
    logic        is_ins, is_rd, in_vld;
    logic [1:0]  kind_sel;
    logic [CNT_W:0] ins_pos;
    logic [31:0] rd_idx;
    logic        rd_hit;

    assign accept = start && (state_reg == pali_pkg::S_IDLE);
    assign busy   = (state_reg != pali_pkg::S_IDLE);

    // Request decode at accept
    always_comb
    begin
        is_ins   = 1'b0;
        is_rd    = 1'b0;
        kind_sel = list_kind;
        unique case (req_type) inside
            pali_pkg::REQ_ADD_PARENT, pali_pkg::REQ_ADD_CHILD,
            pali_pkg::REQ_ADD_NEIGHBOR, pali_pkg::REQ_ADD_SIBLING:
            begin
                is_ins   = 1'b1;
                kind_sel = req_type[1:0];
            end
            pali_pkg::REQ_READ:
            begin
                is_rd = 1'b1;
            end
            default:
            begin
                is_ins = 1'b0;
            end
        endcase
    end

    assign in_vld = (32'(vertex) < VERTICES);

    // Insertion point: end of the target list, never beyond the filled region
    always_comb
    begin
        ins_pos = {1'b0, st_reg} + {1'b0, cnt_reg};
        if (ins_pos > {1'b0, total_reg})
        begin
            ins_pos = {1'b0, total_reg};
        end
    end

    assign rd_idx = 32'(st_reg) + 32'(pos_in_reg);
    assign rd_hit = (32'(pos_in_reg) < 32'(cnt_reg));

    always_comb
    begin
        state_next   = state_reg;
        rot_next     = rot_reg;
        total_next   = total_reg;
        wr_pend_next = wr_pend_reg;
        done_next    = 1'b0;
        slot_next    = slot_reg;
        id_next      = id_reg;
        pos_in_next  = pos_in_reg;
        vld_next     = vld_reg;
        rdreq_next   = rdreq_reg;
        do_ins_next  = do_ins_reg;
        full_next    = full_reg;
        rd_ok_next   = rd_ok_reg;
        st_next      = st_reg;
        cnt_next     = cnt_reg;
        mv_dst_next  = mv_dst_reg;
        wr_addr_next = wr_addr_reg;
        status_next  = status_reg;
        value_next   = value_reg;
        length_next  = length_reg;
        ring_ctl     = '{shift: 1'b0, bump_start: 1'b0, bump_count: 1'b0};
        mem_we       = 1'b0;
        mem_waddr    = wr_addr_reg;
        mem_wdata    = rd_data_reg;
        mem_re       = 1'b0;
        mem_raddr    = '0;

        unique case (state_reg)
            pali_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    slot_next   = SLOT_W'({vertex, kind_sel});
                    id_next     = other_vertex;
                    pos_in_next = position;
                    vld_next    = in_vld;
                    rdreq_next  = is_rd;
                    do_ins_next = in_vld && is_ins && (32'(total_reg) < EDGE_CAPACITY);
                    full_next   = in_vld && is_ins && (32'(total_reg) >= EDGE_CAPACITY);
                    rot_next    = '0;
                    state_next  = pali_pkg::S_SCAN;
                end
            end

            pali_pkg::S_SCAN:
            begin
                // Rotate the ring once; the head carries list rot_reg
                ring_ctl.shift      = 1'b1;
                ring_ctl.bump_count = do_ins_reg && (rot_reg == slot_reg);
                ring_ctl.bump_start = do_ins_reg && (rot_reg > slot_reg);
                if (rot_reg == slot_reg)
                begin
                    st_next  = head_start;
                    cnt_next = head_count;
                end
                if (rot_reg == SLOT_W'(LISTS - 1))
                begin
                    rot_next     = '0;
                    mv_dst_next  = total_reg;
                    wr_pend_next = 1'b0;
                    state_next   = do_ins_reg ? pali_pkg::S_MOVE : pali_pkg::S_RD;
                end
                else
                begin
                    rot_next = rot_reg + 1'b1;
                end
            end

            pali_pkg::S_MOVE:
            begin
                // Retire the entry fetched last cycle
                if (wr_pend_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = wr_addr_reg;
                    mem_wdata = rd_data_reg;
                end
                if ({1'b0, mv_dst_reg} > ins_pos)
                begin
                    mem_re       = 1'b1;
                    mem_raddr    = ADDR_W'(mv_dst_reg - 1'b1);
                    wr_addr_next = ADDR_W'(mv_dst_reg);
                    wr_pend_next = 1'b1;
                    mv_dst_next  = mv_dst_reg - 1'b1;
                end
                else if (wr_pend_reg)
                begin
                    wr_pend_next = 1'b0;
                end
                else
                begin
                    mem_we     = 1'b1;
                    mem_waddr  = ADDR_W'(ins_pos);
                    mem_wdata  = id_reg;
                    total_next = total_reg + 1'b1;
                    state_next = pali_pkg::S_FIN;
                end
            end

            pali_pkg::S_RD:
            begin
                rd_ok_next = rdreq_reg && vld_reg && rd_hit && (rd_idx < EDGE_CAPACITY);
                mem_re     = 1'b1;
                mem_raddr  = ADDR_W'(rd_idx);
                state_next = pali_pkg::S_FIN;
            end

            pali_pkg::S_FIN:
            begin
                if (full_reg)
                begin
                    status_next = pali_pkg::STS_FULL;
                end
                else if (rdreq_reg && !(vld_reg && rd_hit))
                begin
                    status_next = pali_pkg::STS_RANGE;
                end
                else
                begin
                    status_next = pali_pkg::STS_OK;
                end
                value_next = rd_ok_reg ? rd_data_reg : '0;
                if (!vld_reg)
                begin
                    length_next = '0;
                end
                else if (do_ins_reg)
                begin
                    length_next = LEN_W'(cnt_reg + 1'b1);
                end
                else
                begin
                    length_next = LEN_W'(cnt_reg);
                end
                rd_ok_next = 1'b0;
                done_next  = 1'b1;
                state_next = pali_pkg::S_IDLE;
            end

            default:
            begin
                state_next = pali_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= pali_pkg::S_IDLE;
            rot_reg     <= '0;
            total_reg   <= '0;
            wr_pend_reg <= 1'b0;
            done_reg    <= 1'b0;
            rd_ok_reg   <= 1'b0;
            do_ins_reg  <= 1'b0;
            full_reg    <= 1'b0;
            rdreq_reg   <= 1'b0;
            vld_reg     <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            rot_reg     <= rot_next;
            total_reg   <= total_next;
            wr_pend_reg <= wr_pend_next;
            done_reg    <= done_next;
            rd_ok_reg   <= rd_ok_next;
            do_ins_reg  <= do_ins_next;
            full_reg    <= full_next;
            rdreq_reg   <= rdreq_next;
            vld_reg     <= vld_next;
        end
    end

    // Payload registers hold no reset
    always_ff @(posedge clk)
    begin
        slot_reg    <= slot_next;
        id_reg      <= id_next;
        pos_in_reg  <= pos_in_next;
        st_reg      <= st_next;
        cnt_reg     <= cnt_next;
        mv_dst_reg  <= mv_dst_next;
        wr_addr_reg <= wr_addr_next;
        status_reg  <= status_next;
        value_reg   <= value_next;
        length_reg  <= length_next;
    end

    // Edge memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            edge_mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_re)
        begin
            rd_data_reg <= edge_mem[mem_raddr];
        end
    end

    pali_ring #(
        .LISTS(LISTS),
        .CNT_W(CNT_W)
    ) u_ring (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ring_ctl),
        .head_start(head_start),
        .head_count(head_count)
    );

    assign done        = done_reg;
    assign status      = status_reg;
    assign read_value  = value_reg;
    assign list_length = length_reg;
    assign total_edges = LEN_W'(total_reg);

    // The ring must sit aligned (list 0 at the head) whenever no scan runs
    a_ring_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != pali_pkg::S_SCAN) |-> (rot_reg == '0))
        else $error("descriptor ring left misaligned");

    // The fill level never exceeds the store
    a_total_cap: assert property (@(posedge clk) disable iff (!rst_n)
        32'(total_reg) <= EDGE_CAPACITY)
        else $error("edge total beyond capacity");

    // A dropped insert only when the store was full
    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && (status_reg == pali_pkg::STS_FULL)) |-> (32'(total_reg) == EDGE_CAPACITY))
        else $error("full status with room left");

    // The move never runs below the insertion point
    a_move_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == pali_pkg::S_MOVE) |-> ({1'b0, mv_dst_reg} >= ins_pos))
        else $error("move went below insertion point");

    // A result strobe follows the result state only
    a_done_src: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> ($past(state_reg) == pali_pkg::S_FIN))
        else $error("result strobe without finished transaction");

endmodule

/* tb/adjacency_checker.sv */
module adjacency_checker
    import pali_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic             busy,
    input  logic [REQ_W-1:0] req_type,
    input  logic [3:0]       vertex,
    input  logic [ID_W-1:0]  other_vertex,
    input  logic [1:0]       list_kind,
    input  logic [POS_W-1:0] position,
    input  logic             done,
    input  logic [STS_W-1:0] status,
    input  logic [ID_W-1:0]  read_value,
    input  logic [LEN_W-1:0] list_length,
    input  logic [LEN_W-1:0] total_edges,
    output int               errors,
    output int               pending
);

    localparam int NUM_LISTS = 4 * VERTICES_DEF;
    localparam int CAP       = EDGE_CAPACITY_DEF;

    typedef struct packed {
        logic [STS_W-1:0] sts;
        logic [ID_W-1:0]  val;
        logic [LEN_W-1:0] len;
        logic [LEN_W-1:0] tot;
    } reply_t;

    // Shadow copy of the packed store and its list descriptors.
    logic [ID_W-1:0]  edge_mem [CAP];
    logic [LEN_W-1:0] lst_base [NUM_LISTS];
    logic [LEN_W-1:0] lst_len  [NUM_LISTS];
    logic [LEN_W-1:0] edge_cnt;

    reply_t queued_replies [$];

    initial errors = 0;

    function automatic reply_t apply_request(
        input logic [REQ_W-1:0] rq,
        input logic [3:0]       vx,
        input logic [ID_W-1:0]  ov,
        input logic [1:0]       lk,
        input logic [POS_W-1:0] ps
    );
        reply_t r;
        int     slot;
        int     ins_at;
        logic   vx_ok;
        r      = '0;
        vx_ok  = int'(vx) < VERTICES_DEF;
        if (rq <= REQ_ADD_SIBLING) begin
            slot = int'(vx) * 4 + int'(rq);
            if (vx_ok) begin
                if (edge_cnt >= CAP) begin
                    r.sts = STS_FULL;
                end
                else begin
                    // Open a slot at the end of the list, shift everything above it.
                    ins_at = int'(lst_base[slot]) + int'(lst_len[slot]);
                    for (int k = int'(edge_cnt); k > ins_at; k--)
                        edge_mem[k] = edge_mem[k-1];
                    edge_mem[ins_at] = ov;
                    edge_cnt++;
                    for (int k = slot + 1; k < NUM_LISTS; k++)
                        lst_base[k]++;
                    lst_len[slot]++;
                end
                r.len = lst_len[slot];
            end
        end
        else if (rq == REQ_READ) begin
            slot = int'(vx) * 4 + int'(lk);
            if (!vx_ok) begin
                r.sts = STS_RANGE;
            end
            else begin
                r.len = lst_len[slot];
                if (ps < lst_len[slot])
                    r.val = edge_mem[int'(lst_base[slot]) + int'(ps)];
                else
                    r.sts = STS_RANGE;
            end
        end
        else if (vx_ok) begin
            r.len = lst_len[int'(vx) * 4 + int'(lk)];
        end
        r.tot = edge_cnt;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        reply_t want;
        reply_t got;
        if (!rst_n) begin
            edge_cnt = '0;
            for (int i = 0; i < NUM_LISTS; i++) begin
                lst_base[i] = '0;
                lst_len[i]  = '0;
            end
            queued_replies.delete();
            pending <= 0;
        end
        else begin
            // Retire the result first: it always belongs to an older transaction.
            if (done) begin
                got = '{status, read_value, list_length, total_edges};
                if (queued_replies.size() == 0) begin
                    if (errors < 10)
                        $display("unexpected result sts=%0d val=%0d len=%0d tot=%0d",
                                 got.sts, got.val, got.len, got.tot);
                    errors++;
                end
                else begin
                    want = queued_replies.pop_front();
                    if (got !== want) begin
                        if (errors < 10)
                            $display("mismatch exp sts=%0d val=%0d len=%0d tot=%0d, got sts=%0d val=%0d len=%0d tot=%0d",
                                     want.sts, want.val, want.len, want.tot,
                                     got.sts, got.val, got.len, got.tot);
                        errors++;
                    end
                end
            end
            if (start && !busy)
                queued_replies.push_back(apply_request(req_type, vertex, other_vertex,
                                                       list_kind, position));
            pending <= queued_replies.size();
        end
    end

endmodule

/* tb/testbench.sv */
module testbench;
    import pali_pkg::*;

    localparam int NUM_LISTS = 4 * VERTICES_DEF;
    localparam int CAP       = EDGE_CAPACITY_DEF;
    localparam int RAND_ITEMS = 850;
    // Highest request code; everything above REQ_READ is a no-op.
    localparam logic [REQ_W-1:0] REQ_TOP_CODE = {REQ_W{1'b1}};

    logic             clk   = 1'b0;
    logic             rst_n = 1'b0;
    logic             start = 1'b0;
    logic [REQ_W-1:0] req_type     = '0;
    logic [3:0]       vertex       = '0;
    logic [ID_W-1:0]  other_vertex = '0;
    logic [1:0]       list_kind    = '0;
    logic [POS_W-1:0] position     = '0;

    logic             busy;
    logic             done;
    logic [STS_W-1:0] status;
    logic [ID_W-1:0]  read_value;
    logic [LEN_W-1:0] list_length;
    logic [LEN_W-1:0] total_edges;

    int errors;
    int pending;

    // Occupancy mirror used only to steer reads toward filled entries and
    // to know when the store is full; the checker does the real prediction.
    int occ [NUM_LISTS];
    int fill_level = 0;

    packed_adjacency_list_insert_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .req_type     (req_type),
        .vertex       (vertex),
        .other_vertex (other_vertex),
        .list_kind    (list_kind),
        .position     (position),
        .done         (done),
        .status       (status),
        .read_value   (read_value),
        .list_length  (list_length),
        .total_edges  (total_edges)
    );

    adjacency_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .req_type     (req_type),
        .vertex       (vertex),
        .other_vertex (other_vertex),
        .list_kind    (list_kind),
        .position     (position),
        .done         (done),
        .status       (status),
        .read_value   (read_value),
        .list_length  (list_length),
        .total_edges  (total_edges),
        .errors       (errors),
        .pending      (pending)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 0;
    end

    // Present one transaction and hold it until the block takes it. Start
    // stays high while busy, so the block must ignore it until it is idle.
    task automatic issue(
        input logic [REQ_W-1:0] rq,
        input logic [3:0]       vx,
        input logic [ID_W-1:0]  ov,
        input logic [1:0]       lk,
        input logic [POS_W-1:0] ps
    );
        int slot;
        start        <= 1'b1;
        req_type     <= rq;
        vertex       <= vx;
        other_vertex <= ov;
        list_kind    <= lk;
        position     <= ps;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        // Track occupancy: every insert lands until the store is full.
        if (rq <= REQ_ADD_SIBLING && fill_level < CAP) begin
            slot = int'(vx) * 4 + int'(rq);
            occ[slot]++;
            fill_level++;
        end
    endtask

    // Drop start over a gap set by n and scramble the request fields meanwhile, so
    // the block must sample them only on the accepting edge. The gap may end
    // anywhere inside a busy period or after it.
    task automatic hold_off(input int n);
        repeat (n)
        begin
            start        <= 1'b0;
            req_type     <= $urandom;
            vertex       <= $urandom;
            other_vertex <= $urandom;
            list_kind    <= $urandom;
            position     <= $urandom;
            @(posedge clk);
        end
    endtask

    // Stop sending until every outstanding result has come back.
    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    // Build one random transaction: mostly inserts and reads, with reads
    // aimed mainly at entries that exist, plus some past-the-end reads and
    // no-op codes.
    task automatic pick_request(
        output logic [REQ_W-1:0] rq,
        output logic [3:0]       vx,
        output logic [ID_W-1:0]  ov,
        output logic [1:0]       lk,
        output logic [POS_W-1:0] ps
    );
        int roll;
        int sel;
        int slot;
        roll = $urandom_range(0, 99);
        vx   = $urandom;
        ov   = $urandom;
        lk   = $urandom;
        ps   = $urandom;
        if (roll < 58) begin
            rq = $urandom_range(REQ_ADD_PARENT, REQ_ADD_SIBLING);
        end
        else if (roll < 92) begin
            rq   = REQ_READ;
            slot = int'(vx) * 4 + int'(lk);
            sel  = $urandom_range(0, 9);
            if (occ[slot] > 0 && sel < 7)
                ps = $urandom_range(0, occ[slot] - 1);
            else if (sel == 7)
                ps = occ[slot];
        end
        else begin
            rq = $urandom_range(REQ_READ + 1, REQ_TOP_CODE);
        end
    endtask

    initial
    begin
        logic [REQ_W-1:0] rq;
        logic [3:0]       vx;
        logic [ID_W-1:0]  ov;
        logic [1:0]       lk;
        logic [POS_W-1:0] ps;
        int               guard;

        for (int i = 0; i < NUM_LISTS; i++)
            occ[i] = 0;

        // Hold reset at the start, then release it once for the whole run.
        repeat (6)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reads of an empty store, extreme position.
        issue(REQ_READ, 4'd0, 4'd0, 2'd0, '0);
        issue(REQ_READ, 4'd15, 4'd15, 2'd3, '1);
        // One insert of every kind, extreme vertex ids on both sides.
        issue(REQ_ADD_PARENT,   4'd0,  4'd15, 2'd3, '1);
        issue(REQ_ADD_CHILD,    4'd0,  4'd0,  2'd0, '0);
        issue(REQ_ADD_NEIGHBOR, 4'd7,  4'd9,  2'd1, 10'd5);
        issue(REQ_ADD_SIBLING,  4'd15, 4'd15, 2'd2, 10'd1);
        // Append behind an existing entry: every later list must shift.
        issue(REQ_ADD_PARENT,   4'd0,  4'd5,  2'd0, '0);
        issue(REQ_ADD_SIBLING,  4'd15, 4'd3,  2'd0, '0);
        // Read back each list, then one index past the end.
        issue(REQ_READ, 4'd0,  4'd0, 2'd0, 10'd0);
        issue(REQ_READ, 4'd0,  4'd0, 2'd0, 10'd1);
        issue(REQ_READ, 4'd0,  4'd0, 2'd0, 10'd2);
        issue(REQ_READ, 4'd0,  4'd0, 2'd1, 10'd0);
        issue(REQ_READ, 4'd7,  4'd0, 2'd2, 10'd0);
        issue(REQ_READ, 4'd15, 4'd0, 2'd3, 10'd0);
        issue(REQ_READ, 4'd15, 4'd0, 2'd3, 10'd1);
        issue(REQ_READ, 4'd15, 4'd0, 2'd3, '1);
        // No-op codes report the length of (vertex, list_kind).
        issue(REQ_READ + 3'd1, 4'd0,  4'd15, 2'd0, '1);
        issue(REQ_READ + 3'd2, 4'd15, 4'd0,  2'd3, '0);
        issue(REQ_TOP_CODE,    4'd7,  4'd7,  2'd2, 10'd512);

        // Random traffic; leave a long stretch with no gaps at all.
        for (int i = 0; i < RAND_ITEMS; i++)
        begin
            if (i == RAND_ITEMS / 2)
                drain();
            if ((i < 250 || i >= 420) && $urandom_range(0, 99) < 17)
                hold_off($urandom_range(1, 100));
            pick_request(rq, vx, ov, lk, ps);
            issue(rq, vx, ov, lk, ps);
        end

        // Top the store up to capacity, mostly at the tail list where no
        // entries need moving; this also grows one very long list.
        while (fill_level < CAP)
        begin
            if ($urandom_range(0, 99) < 80)
                issue(REQ_ADD_SIBLING, 4'd15, $urandom, $urandom, $urandom);
            else
                issue($urandom_range(REQ_ADD_PARENT, REQ_ADD_SIBLING), $urandom,
                      $urandom, $urandom, $urandom);
        end
        drain();

        // Full store: inserts are dropped, reads reach deep positions.
        for (int i = 0; i < 60; i++)
        begin
            if ($urandom_range(0, 99) < 17)
                hold_off($urandom_range(1, 100));
            pick_request(rq, vx, ov, lk, ps);
            if (i % 4 == 0) begin
                rq = REQ_READ;
                vx = 4'd15;
                lk = 2'd3;
                ps = $urandom_range(0, occ[NUM_LISTS - 1] - 1);
            end
            issue(rq, vx, ov, lk, ps);
        end

        // Wait out the last results, then keep the clock running past them
        // so any stray result still shows up as a failure.
        start <= 1'b0;
        @(posedge clk);
        guard = 0;
        while (pending != 0 && guard < 5000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (4 * NUM_LISTS + 20)
            @(posedge clk);

        if (errors == 0 && pending == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial
    begin
        #10000000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
